// ===== rtl/hsdc_pkg.sv =====
package hsdc_pkg;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CUR_W       = 19;
   localparam int unsigned GAIN_W      = 16;
   localparam int unsigned VEL_THR_W   = 23;
   localparam int unsigned TIME_W      = 16;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned DRIVE_W     = 20;
   localparam int unsigned PROD_W      = 64;
   localparam int unsigned SQ_W        = 48;
   localparam int unsigned ACC_W       = 50;

   localparam logic [CSR_INDEX_W-1:0] REG_HOMING_CURRENT  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REST_CURRENT    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPRING_GAIN     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_QUAD_GAIN       = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DAMPING_GAIN    = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CURRENT_LIMIT   = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_STALL_VELOCITY  = 8'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_STALL_HOLD_MS   = 8'd7;

   typedef struct packed {
      logic [CUR_W-1:0]     homing_current;
      logic [CUR_W-1:0]     rest_current;
      logic [GAIN_W-1:0]    spring_gain;
      logic [GAIN_W-1:0]    quad_gain;
      logic [GAIN_W-1:0]    damping_gain;
      logic [CUR_W-1:0]     current_limit;
      logic [VEL_THR_W-1:0] stall_velocity;
      logic [TIME_W-1:0]    stall_hold_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      homing_current:  19'd114688,
      rest_current:    19'd32768,
      spring_gain:     16'd7864,
      quad_gain:       16'd524,
      damping_gain:    16'd5243,
      current_limit:   19'd249037,
      stall_velocity:  23'd163840,
      stall_hold_ms:   16'd250
   };

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_HOME,
      OP_SQ,
      OP_SPRING,
      OP_QLO,
      OP_QHI,
      OP_DAMP,
      OP_ADD,
      OP_CLAMP,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HOME,
      ST_SQ,
      ST_SPRING,
      ST_QLO,
      ST_QHI,
      ST_DAMP,
      ST_ADD,
      ST_CLAMP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic phase;
      logic disp_pos;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/hsdc_regs.sv =====
module hsdc_regs
   import hsdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_HOMING_CURRENT:  cfg_in.homing_current  = csr_data[CUR_W-1:0];
            REG_REST_CURRENT:    cfg_in.rest_current    = csr_data[CUR_W-1:0];
            REG_SPRING_GAIN:     cfg_in.spring_gain     = csr_data[GAIN_W-1:0];
            REG_QUAD_GAIN:       cfg_in.quad_gain       = csr_data[GAIN_W-1:0];
            REG_DAMPING_GAIN:    cfg_in.damping_gain    = csr_data[GAIN_W-1:0];
            REG_CURRENT_LIMIT:   cfg_in.current_limit   = csr_data[CUR_W-1:0];
            REG_STALL_VELOCITY:  cfg_in.stall_velocity  = csr_data[VEL_THR_W-1:0];
            REG_STALL_HOLD_MS:   cfg_in.stall_hold_ms   = csr_data[TIME_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/hsdc_ctrl.sv =====
module hsdc_ctrl
   import hsdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output op_type     op
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = status.phase ? ST_SQ : ST_HOME;
         ST_HOME:   state_in = ST_EMIT;
         ST_SQ:     state_in = status.disp_pos ? ST_SPRING : ST_CLAMP;
         ST_SPRING: state_in = ST_QLO;
         ST_QLO:    state_in = ST_QHI;
         ST_QHI:    state_in = ST_DAMP;
         ST_DAMP:   state_in = ST_ADD;
         ST_ADD:    state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_EMIT;
         ST_EMIT:   if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      op        = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = OP_LOAD;
         end
         ST_HOME:   op = OP_HOME;
         ST_SQ:     op = OP_SQ;
         ST_SPRING: op = OP_SPRING;
         ST_QLO:    op = OP_QLO;
         ST_QHI:    op = OP_QHI;
         ST_DAMP:   op = OP_DAMP;
         ST_ADD:    op = OP_ADD;
         ST_CLAMP:  op = OP_CLAMP;
         ST_EMIT:   if (status.out_free) op = OP_EMIT;
         default:   op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/hsdc_datapath.sv =====
module hsdc_datapath
   import hsdc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  op_type                    op,
   output status_type                status,
   input  logic signed [WORD_W-1:0]  req_shaft_angle,
   input  logic signed [WORD_W-1:0]  req_shaft_velocity,
   input  logic [WORD_W-1:0]         req_now_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DRIVE_W-1:0] rsp_drive_current,
   output logic                      rsp_feedback_mode,
   output logic                      rsp_home_latched,
   output logic signed [WORD_W-1:0]  rsp_home_position
);

   logic [WORD_W-1:0]  angle_ff;
   logic [WORD_W-1:0]  vel_ff;
   logic [WORD_W-1:0]  now_ff;
   logic [WORD_W:0]    disp_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [DRIVE_W-1:0] drive_ff;
   logic               mode_ff;
   logic               latched_ff;
   logic               phase_ff;
   logic               running_ff;
   logic [WORD_W-1:0]  start_ff;
   logic [WORD_W-1:0]  home_ff;
   logic               rsp_valid_ff;
   logic [DRIVE_W-1:0] rsp_drive_ff;
   logic               rsp_mode_ff;
   logic               rsp_latched_ff;
   logic [WORD_W-1:0]  rsp_home_ff;

   logic [WORD_W-1:0]  mul_a;
   logic [WORD_W-1:0]  mul_b;
   logic               disp_pos;
   logic               vel_pos;
   logic [WORD_W-1:0]  vel_mag;
   logic               stalled;
   logic               timed_out;
   logic [CUR_W-1:0]   target;
   logic               out_free;

   assign disp_pos  = !disp_ff[WORD_W] && (|disp_ff[WORD_W-1:0]);
   assign vel_pos   = !vel_ff[WORD_W-1] && (|vel_ff[WORD_W-2:0]);
   assign vel_mag   = vel_ff[WORD_W-1] ? (WORD_W'(0) - vel_ff) : vel_ff;
   assign stalled   = vel_mag < WORD_W'(cfg.stall_velocity);
   assign timed_out = (now_ff - start_ff) >= WORD_W'(cfg.stall_hold_ms);
   assign target    = (acc_ff > ACC_W'(cfg.current_limit)) ? cfg.current_limit
                                                          : acc_ff[CUR_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign status.phase    = phase_ff;
   assign status.disp_pos = disp_pos;
   assign status.out_free = out_free;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op)
         OP_SQ: begin
            mul_a = disp_ff[WORD_W-1:0];
            mul_b = disp_ff[WORD_W-1:0];
         end
         OP_SPRING: begin
            mul_a = WORD_W'(cfg.spring_gain);
            mul_b = disp_ff[WORD_W-1:0];
         end
         OP_QLO: begin
            mul_a = WORD_W'(cfg.quad_gain);
            mul_b = sq_ff[WORD_W-1:0];
         end
         OP_QHI: begin
            mul_a = WORD_W'(cfg.quad_gain);
            mul_b = WORD_W'(sq_ff[SQ_W-1:WORD_W]);
         end
         OP_DAMP: begin
            mul_a = WORD_W'(cfg.damping_gain);
            mul_b = vel_pos ? vel_ff : '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      unique case (op)
         OP_LOAD: begin
            angle_ff <= req_shaft_angle;
            vel_ff   <= req_shaft_velocity;
            now_ff   <= req_now_ms;
            disp_ff  <= {req_shaft_angle[WORD_W-1], req_shaft_angle}
                        - {home_ff[WORD_W-1], home_ff};
            acc_ff   <= ACC_W'(cfg.rest_current);
         end
         OP_SPRING: sq_ff  <= prod_ff[PROD_W-1:16];
         OP_QLO:    acc_ff <= acc_ff + ACC_W'(prod_ff[PROD_W-1:16]);
         OP_QHI:    acc_ff <= acc_ff + ACC_W'(prod_ff[PROD_W-1:16]);
         OP_DAMP:   acc_ff <= acc_ff + ACC_W'({prod_ff[WORD_W-1:0], 16'b0});
         OP_ADD:    acc_ff <= acc_ff + ACC_W'(prod_ff[PROD_W-1:16]);
         OP_HOME: begin
            drive_ff   <= DRIVE_W'(0) - DRIVE_W'(cfg.homing_current);
            mode_ff    <= 1'b0;
            latched_ff <= !stalled ? 1'b0 : (running_ff && timed_out);
         end
         OP_CLAMP: begin
            drive_ff   <= DRIVE_W'(0) - DRIVE_W'(target);
            mode_ff    <= 1'b1;
            latched_ff <= 1'b0;
         end
         OP_EMIT: begin
            rsp_drive_ff   <= drive_ff;
            rsp_mode_ff    <= mode_ff;
            rsp_latched_ff <= latched_ff;
            rsp_home_ff    <= home_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         running_ff   <= 1'b0;
         start_ff     <= '0;
         home_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (op == OP_HOME) begin
            if (stalled) begin
               if (!running_ff) begin
                  start_ff   <= now_ff;
                  running_ff <= 1'b1;
               end else if (timed_out) begin
                  home_ff  <= angle_ff;
                  phase_ff <= 1'b1;
               end
            end else begin
               running_ff <= 1'b0;
            end
         end
         if (op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_current = rsp_drive_ff;
   assign rsp_feedback_mode = rsp_mode_ff;
   assign rsp_home_latched  = rsp_latched_ff;
   assign rsp_home_position = rsp_home_ff;

endmodule

// ===== rtl/homing_and_spring_damper_current.sv =====
// In homing an accepted beat passes the HOME and EMIT states; in feedback it
// passes SQ, SPRING, QLO, QHI, DAMP, ADD, CLAMP and EMIT (shaft inside home:
// SQ, CLAMP, EMIT), using one shared 32x32 multiplier over five products. The
// next beat is taken once the result sits in the output register.
// Reset: synchronous, active high; registers return to defaults, phase to homing,
// stall timer and home angle to zero.
module homing_and_spring_damper_current
   import hsdc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [WORD_W-1:0]  req_shaft_angle,
   input  logic signed [WORD_W-1:0]  req_shaft_velocity,
   input  logic [WORD_W-1:0]         req_now_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DRIVE_W-1:0] rsp_drive_current,
   output logic                      rsp_feedback_mode,
   output logic                      rsp_home_latched,
   output logic signed [WORD_W-1:0]  rsp_home_position,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   cfg_type    cfg;
   op_type     op;
   status_type status;

   hsdc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hsdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .op        (op)
   );

   hsdc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .op                 (op),
      .status             (status),
      .req_shaft_angle    (req_shaft_angle),
      .req_shaft_velocity (req_shaft_velocity),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_current  (rsp_drive_current),
      .rsp_feedback_mode  (rsp_feedback_mode),
      .rsp_home_latched   (rsp_home_latched),
      .rsp_home_position  (rsp_home_position)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_feedback_mode && rsp_home_latched))
      else $error("home latched on a feedback beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_current[DRIVE_W-1] || rsp_drive_current == '0))
      else $error("drive current positive");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat taken while busy");

endmodule

// ===== tb/drive_command_checker.sv =====
module drive_command_checker
   import hsdc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [WORD_W-1:0]  req_shaft_angle,
   input  logic signed [WORD_W-1:0]  req_shaft_velocity,
   input  logic [WORD_W-1:0]         req_now_ms,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [DRIVE_W-1:0] rsp_drive_current,
   input  logic                      rsp_feedback_mode,
   input  logic                      rsp_home_latched,
   input  logic signed [WORD_W-1:0]  rsp_home_position,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   output int unsigned               mismatch_count,
   output int unsigned               commands_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      mode;
      logic                      latched;
      logic [WORD_W-1:0]         home;
   } drive_cmd_type;

   cfg_type          regs_q;
   logic             feedback_phase;
   logic             stall_armed;
   logic [WORD_W-1:0] stall_t0;
   logic [WORD_W-1:0] home_q;
   drive_cmd_type    due_q[$];
   int unsigned      errors;

   function automatic drive_cmd_type drive_command(input logic signed [WORD_W-1:0] angle,
                                                   input logic signed [WORD_W-1:0] vel,
                                                   input logic [WORD_W-1:0]        now);
      drive_cmd_type c;
      longint      a64, v64, h64, disp;
      logic [63:0] mag, thr, d, sq, target, gain, lim, neg;
      logic [31:0] elapsed;
      a64 = angle;
      v64 = vel;
      c.mode    = feedback_phase;
      c.latched = 1'b0;
      if (!feedback_phase) begin
         target = regs_q.homing_current;
         mag = (v64 < 0) ? -v64 : v64;
         thr = regs_q.stall_velocity;
         if (mag < thr) begin
            if (!stall_armed) begin
               stall_t0    = now;
               stall_armed = 1'b1;
            end else begin
               elapsed = now - stall_t0;
               if (elapsed >= {16'd0, regs_q.stall_hold_ms}) begin
                  home_q         = angle;
                  feedback_phase = 1'b1;
                  c.latched      = 1'b1;
               end
            end
         end else begin
            stall_armed = 1'b0;
         end
      end else begin
         h64    = $signed(home_q);
         disp   = a64 - h64;
         target = regs_q.rest_current;
         if (disp > 0) begin
            d  = disp;
            sq = (d * d) >> 16;
            gain = regs_q.spring_gain;
            target = target + ((gain * d) >> 16);
            gain = regs_q.quad_gain;
            target = target + ((gain * sq) >> 16);
            if (v64 > 0) begin
               gain = regs_q.damping_gain;
               mag  = v64;
               target = target + ((gain * mag) >> 16);
            end
         end
         lim = regs_q.current_limit;
         if (target > lim) target = lim;
      end
      neg     = 64'd0 - target;
      c.drive = neg[DRIVE_W-1:0];
      c.home  = home_q;
      return c;
   endfunction

   always @(posedge clock) begin : watch
      drive_cmd_type want;
      if (reset) begin
         regs_q         = CFG_RESET;
         feedback_phase = 1'b0;
         stall_armed    = 1'b0;
         stall_t0       = '0;
         home_q         = '0;
         due_q.delete();
         errors         = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               if (errors < 10)
                  $display("%0t: result beat with nothing due: drive=%0d mode=%0b latched=%0b home=%0d",
                           $realtime, rsp_drive_current, rsp_feedback_mode, rsp_home_latched,
                           rsp_home_position);
               errors++;
            end else begin
               want = due_q.pop_front();
               if (rsp_drive_current !== want.drive || rsp_feedback_mode !== want.mode ||
                   rsp_home_latched !== want.latched || rsp_home_position !== want.home) begin
                  if (errors < 10) begin
                     $display("%0t: expected drive=%0d mode=%0b latched=%0b home=%0d",
                              $realtime, $signed(want.drive), want.mode, want.latched,
                              $signed(want.home));
                     $display("%0t:   actual drive=%0d mode=%0b latched=%0b home=%0d",
                              $realtime, rsp_drive_current, rsp_feedback_mode,
                              rsp_home_latched, rsp_home_position);
                  end
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_HOMING_CURRENT:  regs_q.homing_current  = csr_data[CUR_W-1:0];
               REG_REST_CURRENT:    regs_q.rest_current    = csr_data[CUR_W-1:0];
               REG_SPRING_GAIN:     regs_q.spring_gain     = csr_data[GAIN_W-1:0];
               REG_QUAD_GAIN:       regs_q.quad_gain       = csr_data[GAIN_W-1:0];
               REG_DAMPING_GAIN:    regs_q.damping_gain    = csr_data[GAIN_W-1:0];
               REG_CURRENT_LIMIT:   regs_q.current_limit   = csr_data[CUR_W-1:0];
               REG_STALL_VELOCITY:  regs_q.stall_velocity  = csr_data[VEL_THR_W-1:0];
               REG_STALL_HOLD_MS:   regs_q.stall_hold_ms   = csr_data[TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            due_q.push_back(drive_command(req_shaft_angle, req_shaft_velocity, req_now_ms));
      end
      mismatch_count <= errors;
      commands_due   <= due_q.size();
   end

endmodule

// ===== tb/homing_and_spring_damper_current_tb.sv =====
module homing_and_spring_damper_current_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsdc_pkg::*;

   localparam int unsigned CUR_MAX        = 327680;
   localparam int unsigned GAIN_MAX       = 65535;
   localparam int unsigned VEL_MAX        = 6553600;
   localparam int unsigned SETTLE_CYCLES  = 12;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [WORD_W-1:0]  req_shaft_angle = '0;
   logic signed [WORD_W-1:0]  req_shaft_velocity = '0;
   logic [WORD_W-1:0]         req_now_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive_current;
   logic                      rsp_feedback_mode;
   logic                      rsp_home_latched;
   logic signed [WORD_W-1:0]  rsp_home_position;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   int unsigned               mismatch_count;
   int unsigned               commands_due;

   bit                        idle_on = 1'b0;
   int unsigned               hold_requests = 0;
   logic signed [WORD_W-1:0]  home_pos = '0;
   logic [WORD_W-1:0]         ms = 32'h0000_2000;

   always #6 clock = ~clock;

   homing_and_spring_damper_current u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_shaft_angle    (req_shaft_angle),
      .req_shaft_velocity (req_shaft_velocity),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_current  (rsp_drive_current),
      .rsp_feedback_mode  (rsp_feedback_mode),
      .rsp_home_latched   (rsp_home_latched),
      .rsp_home_position  (rsp_home_position),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   drive_command_checker u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_shaft_angle    (req_shaft_angle),
      .req_shaft_velocity (req_shaft_velocity),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_current  (rsp_drive_current),
      .rsp_feedback_mode  (rsp_feedback_mode),
      .rsp_home_latched   (rsp_home_latched),
      .rsp_home_position  (rsp_home_position),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .commands_due       (commands_due)
   );

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] with_junk(input logic [31:0] v, input int unsigned w);
      logic [31:0] hi;
      hi = $urandom() << w;
      return $urandom_range(0, 1) ? v : (v | hi);
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.homing_current  = $urandom_range(0, CUR_MAX);
      c.rest_current    = $urandom_range(0, CUR_MAX);
      c.spring_gain     = $urandom_range(0, GAIN_MAX);
      c.quad_gain       = $urandom_range(0, GAIN_MAX);
      c.damping_gain    = $urandom_range(0, GAIN_MAX);
      c.current_limit   = $urandom_range(0, CUR_MAX);
      c.stall_velocity  = $urandom_range(0, VEL_MAX);
      c.stall_hold_ms   = $urandom_range(0, GAIN_MAX);
      return c;
   endfunction

   function automatic logic [31:0] homing_velocity(input logic [VEL_THR_W-1:0] thr);
      int unsigned r;
      logic [31:0] m;
      r = $urandom_range(0, 3);
      if (r < 2 && thr != 0) m = $urandom_range(0, thr - 1);
      else if (r == 2) return $urandom();
      else m = thr + $urandom_range(0, 4096);
      return $urandom_range(0, 1) ? m : -m;
   endfunction

   function automatic logic [31:0] feedback_angle();
      int unsigned k;
      logic [31:0] off;
      k = $urandom_range(0, 32);
      if (k == 32) return $urandom();
      off = $urandom() >> (32 - k);
      return $urandom_range(0, 1) ? home_pos + off : home_pos - off;
   endfunction

   function automatic logic [31:0] feedback_velocity();
      int unsigned k;
      logic [31:0] m;
      k = $urandom_range(0, 32);
      if (k == 32) return $urandom();
      m = $urandom() >> (32 - k);
      return $urandom_range(0, 1) ? m : -m;
   endfunction

   task automatic send_tick(input logic signed [31:0] angle, input logic signed [31:0] vel,
                            input logic [31:0] now);
      int unsigned g;
      req_shaft_angle    <= angle;
      req_shaft_velocity <= vel;
      req_now_ms         <= now;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      g = gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (commands_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      logic [CSR_INDEX_W-1:0] junk;
      drain();
      write_reg(REG_HOMING_CURRENT,  with_junk(c.homing_current, CUR_W));
      write_reg(REG_REST_CURRENT,    with_junk(c.rest_current, CUR_W));
      write_reg(REG_SPRING_GAIN,     with_junk(c.spring_gain, GAIN_W));
      write_reg(REG_QUAD_GAIN,       with_junk(c.quad_gain, GAIN_W));
      write_reg(REG_DAMPING_GAIN,    with_junk(c.damping_gain, GAIN_W));
      write_reg(REG_CURRENT_LIMIT,   with_junk(c.current_limit, CUR_W));
      write_reg(REG_STALL_VELOCITY,  with_junk(c.stall_velocity, VEL_THR_W));
      write_reg(REG_STALL_HOLD_MS,   with_junk(c.stall_hold_ms, TIME_W));
      junk = $urandom_range(8, 255);
      if ($urandom_range(0, 1)) write_reg(junk, $urandom());
      csr_valid <= 1'b0;
   endtask

   // receiver: random back-pressure plus the requested long hold-off
   initial begin : receiver
      int unsigned hold, seen;
      hold = 0;
      seen = 0;
      forever begin
         @(posedge clock);
         if (seen != hold_requests) begin
            seen = hold_requests;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (!idle_on || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            hold = gap_len();
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("homing_and_spring_damper_current verification failed");
      $finish;
   end

   initial begin : stimulus
      cfg_type     c;
      int unsigned s, n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // homing with reset settings, stall broken and timestamp wrapping
      send_tick(32'sd0, 32'h8000_0000, 32'd0);
      send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
      send_tick(-32'sd1, 32'sd163840, 32'd2);
      send_tick(32'sd5, -32'sd163840, 32'd3);
      send_tick(32'sd6, 32'sd163839, 32'hFFFF_FFF0);
      send_tick(32'sd7, -32'sd163839, 32'h0000_0010);
      send_tick(32'sd8, 32'sd0, 32'h0000_0080);
      send_tick(32'sd9, 32'sd200000, 32'h0000_1000);

      c = CFG_RESET;
      c.homing_current = '0;
      c.stall_velocity = '0;
      load_config(c);
      send_tick($urandom(), 32'sd0, 32'd300);
      send_tick($urandom(), 32'sd0, 32'd301);

      c.homing_current = CUR_MAX;
      c.stall_velocity = VEL_MAX;
      c.stall_hold_ms  = GAIN_MAX;
      load_config(c);
      send_tick($urandom(), VEL_MAX - 1, 32'd400);
      send_tick($urandom(), -VEL_MAX, 32'd500);
      send_tick($urandom(), 1 - VEL_MAX, 32'd600);

      // random homing, stall time held at maximum so home never latches
      for (s = 0; s < 5; s++) begin
         c = random_config();
         c.stall_hold_ms = GAIN_MAX;
         idle_on = (s % 2) != 0;
         load_config(c);
         for (n = 0; n < 30; n++) begin
            ms = ms + $urandom_range(0, 40);
            send_tick($urandom(), homing_velocity(c.stall_velocity), ms);
         end
      end

      // latch home with a zero stall time
      c = CFG_RESET;
      c.stall_hold_ms = '0;
      load_config(c);
      home_pos = 32'sd0 - $urandom_range(32'h2000_0000, 32'h4000_0000);
      send_tick($urandom(), 32'sd163840, ms);
      send_tick($urandom(), 32'sd0, ms);
      send_tick(home_pos, -32'sd1, ms);

      load_config(CFG_RESET);
      send_tick(home_pos, 32'sd100000, $urandom());
      send_tick(home_pos - 1, 32'sd100000, $urandom());
      send_tick(32'h8000_0000, 32'sd0, $urandom());
      send_tick(home_pos + 1, 32'sd0, $urandom());
      send_tick(home_pos + 65536, 32'sd65536, $urandom());
      send_tick(home_pos + 65536, -32'sd65536, $urandom());
      send_tick(home_pos + 65536, 32'h7FFF_FFFF, $urandom());
      send_tick(home_pos + 65536, 32'h8000_0000, $urandom());
      send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom());

      for (s = 0; s < 8; s++) begin
         c = random_config();
         case (s)
            0: c = '0;
            1: begin
               c.homing_current  = CUR_MAX;
               c.rest_current    = CUR_MAX;
               c.spring_gain     = GAIN_MAX;
               c.quad_gain       = GAIN_MAX;
               c.damping_gain    = GAIN_MAX;
               c.current_limit   = CUR_MAX;
               c.stall_velocity  = VEL_MAX;
               c.stall_hold_ms   = GAIN_MAX;
            end
            2: c.current_limit = '0;
            3: c.current_limit = CUR_MAX;
            default: ;
         endcase
         idle_on = (s % 3) != 0;
         load_config(c);
         // hold the receiver off while ticks keep coming
         if (s == 6) hold_requests++;
         for (n = 0; n < 115; n++) begin
            if (s == 5 && n == 57) drain();
            send_tick(feedback_angle(), feedback_velocity(), $urandom());
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("homing_and_spring_damper_current verification clean");
      else
         $display("homing_and_spring_damper_current verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/hsdc_pkg.sv
rtl/hsdc_regs.sv
rtl/hsdc_ctrl.sv
rtl/hsdc_datapath.sv
rtl/homing_and_spring_damper_current.sv
tb/drive_command_checker.sv
tb/homing_and_spring_damper_current_tb.sv
